// ----- hw/rtl/ttmc_pkg.sv -----
// Shared types and constants for the tray table motion controller.
// No dependencies; imported by ttmc_step and the top level.
package ttmc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CLIMB_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CLIMB_BITS-1:0]  CLIMB_TICKS_RESET   = 16'd2000;
  localparam logic [SAMPLE_BITS-1:0] CURRENT_LIMIT_RESET = 10'd300;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIMB_TICKS   = 2'd0,
    REG_CURRENT_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_UP_SW       = 4'd1,
    MODE_UP_BTN      = 4'd2,
    MODE_DOWN_SW     = 4'd3,
    MODE_DOWN_BTN    = 4'd4,
    MODE_PIVOT       = 4'd5,
    MODE_HOME_CHECK  = 4'd6,
    MODE_HOME_PIVOT  = 4'd7,
    MODE_HOME_CLIMB  = 4'd8
  } mode_t;

  typedef struct packed {
    logic                   up_switch;
    logic                   up_button;
    logic                   down_switch;
    logic                   down_button;
    logic                   pivot_switch;
    logic                   pivot_button;
    logic                   home_button;
    logic                   limit_near;
    logic                   limit_far;
    logic [SAMPLE_BITS-1:0] current_sample;
  } in_word_t;

  typedef struct packed {
    logic lift_up;
    logic lift_down;
    logic pivot_back;
    logic pivot_away_drive;
    logic busy_res;
    logic at_home;
    logic side_far;
  } out_word_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  pivot_side;
    logic                  home_flag;
    logic [CLIMB_BITS-1:0] climb_count;
  } ctl_state_t;

  typedef struct packed {
    logic [CLIMB_BITS-1:0]  climb_ticks;
    logic [SAMPLE_BITS-1:0] current_limit;
  } ctl_cfg_t;

endpackage

// ----- hw/rtl/ttmc_step.sv -----
// One tick of the controller: drive outputs from the held state and compute the next state.
// Depends on ttmc_pkg.
module ttmc_step (
  input  ttmc_pkg::ctl_state_t state,
  input  ttmc_pkg::ctl_cfg_t   cfg,
  input  ttmc_pkg::in_word_t   word,
  output ttmc_pkg::ctl_state_t state_next,
  output ttmc_pkg::out_word_t  result
);
  import ttmc_pkg::*;

  logic pivoting;
  logic limit_hit;
  logic down_held;
  logic [CLIMB_BITS-1:0] count_inc;

  assign pivoting  = (state.mode == MODE_PIVOT) || (state.mode == MODE_HOME_PIVOT);
  assign limit_hit = state.pivot_side ? word.limit_far : word.limit_near;
  assign down_held = (state.mode == MODE_DOWN_SW) ? word.down_switch : word.down_button;
  assign count_inc = state.climb_count + CLIMB_BITS'(1);

  // Outputs show the mode held at the start of the tick
  always_comb begin
    result.lift_up          = (state.mode == MODE_UP_SW) || (state.mode == MODE_UP_BTN) ||
                              (state.mode == MODE_HOME_CLIMB);
    result.lift_down        = (state.mode == MODE_DOWN_SW) || (state.mode == MODE_DOWN_BTN);
    result.pivot_back       = pivoting && state.pivot_side;
    result.pivot_away_drive = pivoting && !state.pivot_side;
    result.busy_res         = (state.mode != MODE_IDLE);
    result.at_home          = state.home_flag;
    result.side_far         = state.pivot_side;
  end

  always_comb begin
    state_next = state;
    unique case (state.mode)
      MODE_IDLE: begin
        if (word.up_switch) state_next.mode = MODE_UP_SW;
        else if (word.up_button) state_next.mode = MODE_UP_BTN;
        else if (word.down_switch) state_next.mode = MODE_DOWN_SW;
        else if (word.down_button) state_next.mode = MODE_DOWN_BTN;
        else if (word.pivot_switch || word.pivot_button) state_next.mode = MODE_PIVOT;
        else if (word.home_button && !state.home_flag) state_next.mode = MODE_HOME_CHECK;
      end
      MODE_UP_SW: begin
        if (!word.up_switch) state_next.mode = MODE_IDLE;
      end
      MODE_UP_BTN: begin
        if (!word.up_button) state_next.mode = MODE_IDLE;
      end
      MODE_DOWN_SW, MODE_DOWN_BTN: begin
        if (!down_held || (word.current_sample >= cfg.current_limit)) begin
          state_next.home_flag = 1'b0;
          state_next.mode      = MODE_IDLE;
        end
      end
      MODE_PIVOT: begin
        if (limit_hit) begin
          state_next.pivot_side = !state.pivot_side;
          state_next.home_flag  = 1'b0;
          state_next.mode       = MODE_IDLE;
        end
      end
      MODE_HOME_CHECK, MODE_HOME_PIVOT: begin
        // home check goes straight to the climb when already on the far side
        if ((state.mode == MODE_HOME_CHECK) && !state.pivot_side) begin
          state_next.mode = MODE_HOME_PIVOT;
        end else if ((state.mode == MODE_HOME_CHECK) || limit_hit) begin
          if (state.mode == MODE_HOME_PIVOT) state_next.pivot_side = !state.pivot_side;
          state_next.climb_count = '0;
          if (cfg.climb_ticks == '0) begin
            state_next.home_flag = 1'b1;
            state_next.mode      = MODE_IDLE;
          end else begin
            state_next.mode = MODE_HOME_CLIMB;
          end
        end
      end
      MODE_HOME_CLIMB: begin
        state_next.climb_count = count_inc;
        if (count_inc >= cfg.climb_ticks) begin
          state_next.home_flag = 1'b1;
          state_next.mode      = MODE_IDLE;
        end
      end
      default: begin
        state_next.mode = MODE_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tray_table_motion_controller_top.sv -----
// Tray table motion controller: config registers, control state and result register.
// Depends on ttmc_pkg and ttmc_step.
//
// Usage:
//   Each input word on in_data is one millisecond tick of sampled buttons,
//   switches, pivot limits and a current sample, taken when in_valid and
//   in_ready are both high. Each accepted word yields exactly one result
//   word on out_data, handed over when out_valid and out_ready are high.
//   The result is in the output register on the cycle after acceptance.
//   Throughput is one word per cycle while the receiver keeps up, set by the
//   single state update between the control registers and the output register.
//   If the receiver stalls, the result holds and in_ready drops until the
//   result is taken; in_ready is high whenever the output register is empty
//   or being emptied in the same cycle.
//   Reset empties the output register and loads climb_ticks = 2000,
//   current_limit = 300, and starts the homing sequence (pivot check).
//   cfg_we writes cfg_data into register cfg_index (0 climb_ticks,
//   1 current_limit); other indexes are ignored. Write only while idle.
module tray_table_motion_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ttmc_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ttmc_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ttmc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ttmc_pkg::CFG_BITS-1:0]       cfg_data
);
  import ttmc_pkg::*;

  ctl_cfg_t   cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  out_word_t  result;
  logic       in_take;

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  ttmc_step u_step (
    .state      (state),
    .cfg        (cfg),
    .word       (in_data),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.climb_ticks   <= CLIMB_TICKS_RESET;
      cfg.current_limit <= CURRENT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIMB_TICKS:   cfg.climb_ticks   <= cfg_data[CLIMB_BITS-1:0];
        REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_HOME_CHECK;
      state.pivot_side  <= 1'b0;
      state.home_flag   <= 1'b0;
      state.climb_count <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Hold the result until taken; load a fresh one on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= result;
    end
  end

endmodule
